@@ rtl/core/four_entry_fifo_assoc_cache_unit_assert.svh @@
// Assertion macros used by the checker file
`ifndef FOUR_ENTRY_FIFO_ASSOC_CACHE_UNIT_ASSERT_SVH
`define FOUR_ENTRY_FIFO_ASSOC_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication
`define FAC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Delayed implication: the consequent is checked after the antecedent
`define FAC_ASSERT_LAT2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/fac_pkg.sv @@
package fac_pkg;

   localparam int TAG_WIDTH  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int NUM_LINES  = 4;
   localparam int LINE_W     = $clog2(NUM_LINES);
   localparam int STATE_W    = 2;

   localparam logic [STATE_W-1:0] STATE_INVALID = '0;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_LOAD   = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic                  valid;
      op_type                op;
      logic [TAG_WIDTH-1:0]  address;
      logic [LINE_W-1:0]     line_index;
      logic [STATE_W-1:0]    new_state;
      logic [DATA_WIDTH-1:0] new_data;
   } cmd_type;

   typedef struct packed {
      logic                  hit;
      logic [LINE_W-1:0]     hit_line;
      logic [STATE_W-1:0]    line_state;
      logic [DATA_WIDTH-1:0] line_data;
      logic [LINE_W-1:0]     written_line;
   } rsp_type;

endpackage

@@ rtl/core/four_entry_fifo_assoc_cache_unit.sv @@
// Four-line fully associative cache with first-in first-out replacement.
// One access is taken per clock: a command is transferred when start is high
// and busy is low. Its result is driven on the rsp_ ports with rsp_strobe
// high for one cycle. The command is held in the input register, goes
// through the four tag compares, and its result is held in the result
// register before it reaches the rsp_ ports. The receiver cannot stall, so
// results must be captured when rsp_strobe is high.
// busy is high only during reset and the cycle after it. Lookup reports the
// first line whose tag matches (whatever its state), or line 0 on a miss.
// Load fills the first invalid line, or shifts the lines down and fills the
// last place when all are valid; update overwrites the named line.
module four_entry_fifo_assoc_cache_unit
   import fac_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [TAG_WIDTH-1:0]         req_address,
   input  logic [LINE_W-1:0]            req_line_index,
   input  logic [STATE_W-1:0]           req_new_state,
   input  logic signed [DATA_WIDTH-1:0] req_new_data,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic [LINE_W-1:0]            rsp_hit_line,
   output logic [STATE_W-1:0]           rsp_line_state,
   output logic signed [DATA_WIDTH-1:0] rsp_line_data,
   output logic [LINE_W-1:0]            rsp_written_line
);

   logic    busy_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   rsp_type store_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      cmd_in.valid      = start && !busy_ff;
      cmd_in.op         = op_type'(req_opcode);
      cmd_in.address    = req_address;
      cmd_in.line_index = req_line_index;
      cmd_in.new_state  = req_new_state;
      cmd_in.new_data   = DATA_WIDTH'(req_new_data);
   end

   fac_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .rsp   (store_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         cmd_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         cmd_ff.valid <= cmd_in.valid;
         rsp_valid_ff <= cmd_ff.valid;
      end
      cmd_ff.op         <= cmd_in.op;
      cmd_ff.address    <= cmd_in.address;
      cmd_ff.line_index <= cmd_in.line_index;
      cmd_ff.new_state  <= cmd_in.new_state;
      cmd_ff.new_data   <= cmd_in.new_data;
      rsp_ff            <= store_rsp;
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_hit_line     = rsp_ff.hit_line;
   assign rsp_line_state   = rsp_ff.line_state;
   assign rsp_line_data    = $signed(rsp_ff.line_data);
   assign rsp_written_line = rsp_ff.written_line;

endmodule

@@ rtl/core/fac_store.sv @@
module fac_store
   import fac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output rsp_type rsp
);

   logic [STATE_W-1:0]    states_ff [NUM_LINES];
   logic [STATE_W-1:0]    states_in [NUM_LINES];
   logic [TAG_WIDTH-1:0]  tags_ff   [NUM_LINES];
   logic [TAG_WIDTH-1:0]  tags_in   [NUM_LINES];
   logic [DATA_WIDTH-1:0] words_ff  [NUM_LINES];
   logic [DATA_WIDTH-1:0] words_in  [NUM_LINES];

   logic              found;
   logic [LINE_W-1:0] sel;
   logic              free_found;
   logic [LINE_W-1:0] target;

   // first matching tag, state ignored
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         if (!found && tags_ff[i] == cmd.address) begin
            found = 1'b1;
            sel   = LINE_W'(i);
         end
      end
   end

   // first invalid line, else the last place after a shift
   always_comb begin
      free_found = 1'b0;
      target     = LINE_W'(NUM_LINES - 1);
      for (int i = 0; i < NUM_LINES; i++) begin
         if (!free_found && states_ff[i] == STATE_INVALID) begin
            free_found = 1'b1;
            target     = LINE_W'(i);
         end
      end
   end

   always_comb begin
      states_in = states_ff;
      tags_in   = tags_ff;
      words_in  = words_ff;
      rsp       = '0;
      if (cmd.valid) begin
         case (cmd.op)
            OP_LOOKUP: begin
               rsp.hit        = found;
               rsp.hit_line   = sel;
               rsp.line_state = states_ff[sel];
               rsp.line_data  = words_ff[sel];
            end
            OP_LOAD: begin
               if (!free_found) begin
                  // drop the oldest line, advance the rest
                  for (int i = 0; i < NUM_LINES - 1; i++) begin
                     states_in[i] = states_ff[i+1];
                     tags_in[i]   = tags_ff[i+1];
                     words_in[i]  = words_ff[i+1];
                  end
               end
               states_in[target] = cmd.new_state;
               tags_in[target]   = cmd.address;
               words_in[target]  = cmd.new_data;
               rsp.written_line  = target;
            end
            OP_UPDATE: begin
               states_in[cmd.line_index] = cmd.new_state;
               tags_in[cmd.line_index]   = cmd.address;
               words_in[cmd.line_index]  = cmd.new_data;
               rsp.written_line          = cmd.line_index;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            states_ff[i] <= STATE_INVALID;
            tags_ff[i]   <= '0;
            words_ff[i]  <= '1;
         end
      end else begin
         states_ff <= states_in;
         tags_ff   <= tags_in;
         words_ff  <= words_in;
      end
   end

endmodule

@@ rtl/core/fac_checker.sv @@
`include "four_entry_fifo_assoc_cache_unit_assert.svh"

module fac_checker
   import fac_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic                         rsp_hit,
   input logic [LINE_W-1:0]            rsp_hit_line,
   input logic signed [DATA_WIDTH-1:0] rsp_line_data,
   input logic [LINE_W-1:0]            rsp_written_line
);

   // every transfer yields exactly one result
   `FAC_ASSERT_LAT2(a_result_follows, clock, reset, start && !busy, rsp_strobe)
   `FAC_ASSERT_LAT2(a_no_spurious, clock, reset, !(start && !busy), !rsp_strobe)
   // a miss reports line 0
   `FAC_ASSERT_NOW(a_miss_line0, clock, reset, rsp_strobe && !rsp_hit, rsp_hit_line == '0)
   // a write to a line other than 0 reports no hit and zero data
   `FAC_ASSERT_NOW(a_write_no_hit, clock, reset,
      rsp_strobe && rsp_written_line != '0, !rsp_hit && rsp_line_data == '0)

endmodule

bind four_entry_fifo_assoc_cache_unit fac_checker u_fac_checker (.*);
